/* rtl/gmnc_pkg.sv */
// Shared types, constants and the 3x3 count function for the grid mine
// neighbour count block. No dependencies.
package gmnc_pkg;

  // Default grid limits, handed to the top-level parameters
  localparam int MAX_COLS_DEF = 32;
  localparam int MAX_ROWS_DEF = 32;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_ADDR_W-1:0] REG_ROW_COUNT = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_COL_COUNT = CFG_ADDR_W'(1);

  localparam logic [CFG_DATA_W-1:0] ROW_COUNT_RST = CFG_DATA_W'(8);
  localparam logic [CFG_DATA_W-1:0] COL_COUNT_RST = CFG_DATA_W'(10);

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic       cell_is_mine;
    logic [3:0] mine_count;
    logic       frame_last;
  } res_t;

  // Up to two results written into the queue in one cycle, in order
  typedef struct packed {
    logic [1:0] n_items;
    res_t       res0;
    res_t       res1;
  } push_t;

  // Column vectors are {bottom, center, top}; the center cell is mid[1].
  function automatic res_t cell_result(input logic [2:0] left, input logic [2:0] mid,
                                       input logic [2:0] right, input logic last);
    res_t       r;
    logic [3:0] sum;
    sum = 4'(left[0]) + 4'(left[1]) + 4'(left[2])
        + 4'(mid[0]) + 4'(mid[2])
        + 4'(right[0]) + 4'(right[1]) + 4'(right[2]);
    r.cell_is_mine = mid[1];
    r.mine_count   = mid[1] ? 4'd0 : sum;
    r.frame_last   = last;
    return r;
  endfunction

endpackage

/* rtl/gmnc_if.sv */
// Valid/ready channel interfaces for the cell input, the result output and
// the configuration write port. Depends on gmnc_pkg.
interface gmnc_in_if;
  logic valid;
  logic ready;
  logic is_mine;

  modport source (output valid, output is_mine, input ready);
  modport sink (input valid, input is_mine, output ready);
endinterface

interface gmnc_out_if;
  logic       valid;
  logic       ready;
  logic       cell_is_mine;
  logic [3:0] mine_count;
  logic       frame_last;

  modport source (output valid, output cell_is_mine, output mine_count,
                  output frame_last, input ready);
  modport sink (input valid, input cell_is_mine, input mine_count,
                input frame_last, output ready);
endinterface

interface gmnc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gmnc_pkg::CFG_ADDR_W-1:0] addr;
  logic [gmnc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

/* rtl/grid_mine_neighbour_count_top.sv */
// A cell's results pass the input stage register, then the result queue, to the output.
// Throughput: one cell per cycle while the queue has room; it drains one result a cycle.
// At the frame's last cell the final row drains from the column history, one result a
// cycle while the queue is not full: input holds off until the row's last result is queued.
// Reset (async, active low): position, queue and drain clear; 8 rows, 10 columns.
// Top level of the grid mine neighbour count: configuration registers, scan
// datapath and result queue. Depends on gmnc_pkg and the channel interfaces.
module grid_mine_neighbour_count_top #(
  parameter int MAX_COLS = gmnc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gmnc_pkg::MAX_ROWS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  gmnc_cfg_if.sink     cfg_i,
  gmnc_in_if.sink      in_i,
  gmnc_out_if.source   out_o
);
  import gmnc_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [RW-1:0]         last_row;
  logic [CW-1:0]         last_col;
  logic                  restart;
  logic [FIFO_CNT_W-1:0] fifo_count;
  push_t                 push;
  res_t                  out_res;

  gmnc_cfg #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_ready_o (cfg_i.ready),
    .cfg_addr_i  (cfg_i.addr),
    .cfg_data_i  (cfg_i.data),
    .last_row_o  (last_row),
    .last_col_o  (last_col),
    .restart_o   (restart)
  );

  gmnc_scan #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (restart),
    .last_row_i   (last_row),
    .last_col_i   (last_col),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .is_mine_i    (in_i.is_mine),
    .fifo_count_i (fifo_count),
    .push_o       (push)
  );

  gmnc_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_res_o   (out_res),
    .count_o     (fifo_count)
  );

  // Unpack the result onto the output channel
  assign out_o.cell_is_mine = out_res.cell_is_mine;
  assign out_o.mine_count   = out_res.mine_count;
  assign out_o.frame_last   = out_res.frame_last;

endmodule

/* rtl/gmnc_cfg.sv */
// Configuration registers (row and column count) with clamped last-row and
// last-column limits and a frame restart pulse. Depends on gmnc_pkg.
module gmnc_cfg #(
  parameter int MAX_COLS = gmnc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gmnc_pkg::MAX_ROWS_DEF,
  localparam int CW = $clog2(MAX_COLS),
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gmnc_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [gmnc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [RW-1:0]                   last_row_o,
  output logic [CW-1:0]                   last_col_o,
  output logic                            restart_o
);
  import gmnc_pkg::*;

  logic [CFG_DATA_W-1:0] row_count_q, row_count_d;
  logic [CFG_DATA_W-1:0] col_count_q, col_count_d;
  logic                  wr_en;

  // Always take a write transaction
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i && cfg_ready_o;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    row_count_d = row_count_q;
    col_count_d = col_count_q;
    restart_o   = 1'b0;
    if (wr_en) begin
      case (cfg_addr_i)
        REG_ROW_COUNT: begin
          row_count_d = cfg_data_i;
          restart_o   = 1'b1;
        end
        REG_COL_COUNT: begin
          col_count_d = cfg_data_i;
          restart_o   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROW_COUNT_RST;
      col_count_q <= COL_COUNT_RST;
    end else begin
      row_count_q <= row_count_d;
      col_count_q <= col_count_d;
    end
  end

  // Clamp rows to 1..MAX_ROWS and columns to 2..MAX_COLS, as last indexes
  always_comb begin
    if (row_count_q == '0) begin
      last_row_o = '0;
    end else if (int'(row_count_q) > MAX_ROWS) begin
      last_row_o = RW'(MAX_ROWS - 1);
    end else begin
      last_row_o = RW'(row_count_q - CFG_DATA_W'(1));
    end
    if (row_count_q == '1 && col_count_q == '1) begin
      last_col_o = CW'(MAX_COLS - 1);
    end else if (col_count_q < CFG_DATA_W'(2)) begin
      last_col_o = CW'(1);
    end else if (int'(col_count_q) > MAX_COLS) begin
      last_col_o = CW'(MAX_COLS - 1);
    end else begin
      last_col_o = CW'(col_count_q - CFG_DATA_W'(1));
    end
  end

endmodule

/* rtl/gmnc_scan.sv */
// Raster scan datapath: position counters, two-row column history, input
// stage, 3x3 window and the final-row drain sequencer. Depends on gmnc_pkg.
module gmnc_scan #(
  parameter int MAX_COLS = gmnc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gmnc_pkg::MAX_ROWS_DEF,
  localparam int CW = $clog2(MAX_COLS),
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            restart_i,
  input  logic [RW-1:0]                   last_row_i,
  input  logic [CW-1:0]                   last_col_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            is_mine_i,
  input  logic [gmnc_pkg::FIFO_CNT_W-1:0] fifo_count_i,
  output gmnc_pkg::push_t                 push_o
);
  import gmnc_pkg::*;

  localparam int PW  = $clog2(MAX_COLS + 1);
  localparam int QW  = FIFO_CNT_W + 1;

  // Position of the next cell
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;

  // Per column: {mark of the latest row, mark of the row above it}
  logic [1:0]    hist_q [MAX_COLS];

  // Input stage
  logic          s1_valid_q;
  logic [2:0]    s1_col_q;
  logic          s1_first_q;
  logic          s1_row_end_q;
  logic          s1_above_q;
  logic          s1_frame_end_q;

  // Window columns c-1 and c-2
  logic [2:0]    win1_q, win2_q;

  // Final-row drain
  logic          frame_pending_q;
  logic          drain_q;
  logic [PW-1:0] ptr_q;
  logic [2:0]    dwin1_q, dwin2_q;

  logic          acc;
  logic [CW-1:0] rd_addr;
  logic [1:0]    rd_raw;
  logic [1:0]    above;
  logic          row_end;
  logic          frame_end;
  logic [PW-1:0] cols;
  logic          emit_a, emit_b;
  res_t          res_a, res_b, res_d;
  logic [1:0]    scan_n;
  logic [QW-1:0] room_need;
  logic          drain_at_end;
  logic [2:0]    dcol;
  logic          drain_step;
  logic          drain_emit;

  // Share the history read port between scan and drain
  assign rd_addr   = drain_q ? ptr_q[CW-1:0] : col_q;
  assign rd_raw    = hist_q[rd_addr];
  assign above     = (row_q != '0) ? rd_raw : 2'b00;
  assign row_end   = (col_q == last_col_i);
  assign frame_end = row_end && (row_q == last_row_i);
  assign cols      = PW'(last_col_i) + PW'(1);

  // Results for the registered cell: diagonal up-left, then end of row
  assign emit_a = s1_valid_q && s1_above_q && !s1_first_q;
  assign emit_b = s1_valid_q && s1_above_q && s1_row_end_q;
  assign res_a  = cell_result(win2_q, win1_q, s1_col_q, 1'b0);
  assign res_b  = cell_result(win1_q, s1_col_q, 3'b000, 1'b0);
  assign scan_n = {1'b0, emit_a} + {1'b0, emit_b};

  // Take a cell only if the queue can absorb two more results behind those in flight
  assign room_need  = QW'(fifo_count_i) + QW'(scan_n) + QW'(2);
  assign acc        = in_valid_i && in_ready_o;
  assign in_ready_o = !frame_pending_q && (room_need <= QW'(FIFO_DEPTH));

  // Final-row drain trails the read by a column, one a cycle if the queue has room
  assign drain_at_end = (ptr_q == cols);
  assign dcol         = drain_at_end ? 3'b000 : {1'b0, rd_raw};
  assign drain_step   = drain_q &&
                        ((ptr_q == '0) || (fifo_count_i < FIFO_CNT_W'(FIFO_DEPTH)));
  assign drain_emit   = drain_step && (ptr_q != '0);
  assign res_d        = cell_result(dwin2_q, dwin1_q, dcol, drain_at_end);

  // Select what goes into the result queue this cycle
  always_comb begin
    push_o = '0;
    if (drain_emit) begin
      push_o.n_items = 2'd1;
      push_o.res0    = res_d;
    end else if (emit_a) begin
      push_o.n_items = emit_b ? 2'd2 : 2'd1;
      push_o.res0    = res_a;
      push_o.res1    = res_b;
    end else if (emit_b) begin
      push_o.n_items = 2'd1;
      push_o.res0    = res_b;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q           <= '0;
      col_q           <= '0;
      s1_valid_q      <= 1'b0;
      win1_q          <= '0;
      win2_q          <= '0;
      frame_pending_q <= 1'b0;
      drain_q         <= 1'b0;
      ptr_q           <= '0;
      dwin1_q         <= '0;
      dwin2_q         <= '0;
    end else begin
      // Advance the raster position
      if (restart_i) begin
        row_q <= '0;
        col_q <= '0;
      end else if (acc) begin
        if (frame_end) begin
          row_q <= '0;
          col_q <= '0;
        end else if (row_end) begin
          row_q <= row_q + RW'(1);
          col_q <= '0;
        end else begin
          col_q <= col_q + CW'(1);
        end
      end

      s1_valid_q <= acc;

      // Hold off input from the frame's last cell until the drain ends
      if (acc && frame_end) begin
        frame_pending_q <= 1'b1;
      end else if (drain_step && drain_at_end) begin
        frame_pending_q <= 1'b0;
      end

      // Shift the window; clear it at each row end
      if (restart_i) begin
        win1_q <= '0;
        win2_q <= '0;
      end else if (s1_valid_q) begin
        if (s1_row_end_q) begin
          win1_q <= '0;
          win2_q <= '0;
        end else begin
          win2_q <= win1_q;
          win1_q <= s1_col_q;
        end
      end

      // Run the drain sequencer
      if (s1_valid_q && s1_frame_end_q) begin
        drain_q <= 1'b1;
        ptr_q   <= '0;
        dwin1_q <= '0;
        dwin2_q <= '0;
      end else if (drain_step) begin
        dwin2_q <= dwin1_q;
        dwin1_q <= dcol;
        ptr_q   <= ptr_q + PW'(1);
        if (drain_at_end) begin
          drain_q <= 1'b0;
        end
      end
    end
  end

  // History write and input stage payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      hist_q[col_q]  <= {is_mine_i, above[1]};
      s1_col_q       <= {is_mine_i, above};
      s1_first_q     <= (col_q == '0);
      s1_row_end_q   <= row_end;
      s1_above_q     <= (row_q != '0);
      s1_frame_end_q <= frame_end;
    end
  end

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= last_col_i)
    else $error("column position beyond the last column");

  a_drain_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> (frame_pending_q && !s1_valid_q))
    else $error("drain overlaps scan traffic");

  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain_step && drain_at_end) |=> (!drain_q && !frame_pending_q))
    else $error("drain did not release the input after the last result");

endmodule

/* rtl/gmnc_result_fifo.sv */
// Result queue: takes up to two results a cycle, gives one a cycle to the
// output channel while it is ready. Depends on gmnc_pkg.
module gmnc_result_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gmnc_pkg::push_t                 push_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output gmnc_pkg::res_t                  out_res_o,
  output logic [gmnc_pkg::FIFO_CNT_W-1:0] count_o
);
  import gmnc_pkg::*;

  res_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  pop;

  assign out_valid_o = (count_q != '0);
  assign out_res_o   = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign count_o     = count_q;
  assign count_d     = count_q + FIFO_CNT_W'(push_i.n_items) - FIFO_CNT_W'(pop);

  // Write storage
  always_ff @(posedge clk_i) begin
    if (push_i.n_items != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.n_items == 2'd2) begin
      mem_q[wr_ptr_q + FIFO_PTR_W'(1)] <= push_i.res1;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push_i.n_items);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue occupancy out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (FIFO_CNT_W'(count_q) + FIFO_CNT_W'(push_i.n_items)) <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue written while full");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.n_items == 2'd0) |=> (count_q == $past(count_q) - FIFO_CNT_W'(1)))
    else $error("result queue occupancy did not drop on a pop");

endmodule

/* tb/sv/grid_mine_neighbour_count_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for grid_mine_neighbour_count_top: a cell tracker class predicts
// each neighbour count. Depends on gmnc_pkg, the gmnc channel interfaces and the top level.
module grid_mine_neighbour_count_top_test;
  import gmnc_pkg::*;

  localparam int unsigned COLS_MAX      = MAX_COLS_DEF;
  localparam int unsigned ROWS_MAX      = MAX_ROWS_DEF;
  localparam int unsigned RANDOM_ITEMS  = 260;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned STUCK_LIMIT   = 2000;
  localparam int unsigned REPORT_MAX    = 10;

  // Indexes past the register list: writes there must change nothing
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = CFG_ADDR_W'(15);

  typedef enum int unsigned {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  // Tracks the grid position and the last three rows, and holds the awaited results
  class neighbour_count_tracker;
    logic [CFG_DATA_W-1:0] rows_reg;
    logic [CFG_DATA_W-1:0] cols_reg;
    bit                    row_bits [3][COLS_MAX];
    int                    row_pos;
    int                    col_pos;
    int                    slot;
    res_t                  awaited_q [$];
    int unsigned           faults;

    function new();
      rows_reg = ROW_COUNT_RST;
      cols_reg = COL_COUNT_RST;
      foreach (row_bits[i, j]) row_bits[i][j] = 1'b0;
      row_pos = 0;
      col_pos = 0;
      slot    = 0;
      faults  = 0;
    endfunction

    function int rows_used();
      if (rows_reg < 1) return 1;
      if (rows_reg > ROWS_MAX) return ROWS_MAX;
      return int'(rows_reg);
    endfunction

    function int cols_used();
      if (cols_reg < 2) return 2;
      if (cols_reg > COLS_MAX) return COLS_MAX;
      return int'(cols_reg);
    endfunction

    function int unsigned frame_cells();
      return rows_used() * cols_used();
    endfunction

    function int unsigned waiting();
      return awaited_q.size();
    endfunction

    // A write to a real register restarts the frame; the rows keep their bits
    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_ROW_COUNT) rows_reg = val;
      else if (idx == REG_COL_COUNT) cols_reg = val;
      else return;
      row_pos = 0;
      col_pos = 0;
      slot    = 0;
    endfunction

    // Mark at absolute row x, column y, seen from current row cur
    function bit mark_at(int x, int y, int cur);
      int back;
      back = cur - x;
      if (back > 2 || y >= COLS_MAX) return 1'b0;
      return row_bits[(slot + 3 - back) % 3][y];
    endfunction

    function res_t cell_outcome(int rr, int cc, int cur, int rows, int cols, bit last);
      res_t res;
      int   cnt;
      int   x;
      int   y;
      res.cell_is_mine = mark_at(rr, cc, cur);
      cnt = 0;
      if (!res.cell_is_mine) begin
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            x = rr + dr;
            y = cc + dc;
            if (dr == 0 && dc == 0) continue;
            if (x < 0 || y < 0 || x >= rows || y >= cols || x > cur) continue;
            cnt += mark_at(x, y, cur);
          end
        end
      end
      res.mine_count = 4'(cnt);
      res.frame_last = last;
      return res;
    endfunction

    // Store an accepted cell and queue every result it releases
    function void take_cell(bit is_mine);
      int  rows;
      int  cols;
      int  r;
      int  c;
      bit  row_end;
      bit  frame_end;
      rows = rows_used();
      cols = cols_used();
      r    = row_pos;
      c    = (col_pos >= COLS_MAX) ? COLS_MAX - 1 : col_pos;
      row_bits[slot][c] = is_mine;
      row_end   = (c >= cols - 1);
      frame_end = row_end && (r >= rows - 1);
      if (r >= 1 && c >= 1)
        awaited_q.push_back(cell_outcome(r - 1, c - 1, r, rows, cols, 1'b0));
      if (row_end && r >= 1)
        awaited_q.push_back(cell_outcome(r - 1, cols - 1, r, rows, cols, 1'b0));
      if (frame_end) begin
        for (int j = 0; j < cols; j++)
          awaited_q.push_back(cell_outcome(r, j, r, rows, cols, j == cols - 1));
        row_pos = 0;
        col_pos = 0;
        slot    = 0;
      end else if (row_end) begin
        col_pos = 0;
        row_pos = r + 1;
        slot    = (slot + 1) % 3;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    // Compare one accepted result with the oldest awaited one
    function void match_result(res_t got);
      res_t want;
      if (awaited_q.size() == 0) begin
        faults++;
        if (faults <= REPORT_MAX)
          $display("unexpected result: mine=%0d count=%0d last=%0d",
                   got.cell_is_mine, got.mine_count, got.frame_last);
        return;
      end
      want = awaited_q.pop_front();
      if (got.cell_is_mine !== want.cell_is_mine || got.mine_count !== want.mine_count ||
          got.frame_last !== want.frame_last) begin
        faults++;
        if (faults <= REPORT_MAX)
          $display("mismatch (mine/count/last): expected %0d/%0d/%0d, got %0d/%0d/%0d",
                   want.cell_is_mine, want.mine_count, want.frame_last,
                   got.cell_is_mine, got.mine_count, got.frame_last);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  gmnc_cfg_if reg_if ();
  gmnc_in_if  cell_if ();
  gmnc_out_if res_if ();

  neighbour_count_tracker sb = new();

  idle_mode_e  idle_mode = IDLE_NONE;
  int unsigned hold_req  = 0;

  grid_mine_neighbour_count_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (reg_if),
    .in_i   (cell_if),
    .out_o  (res_if)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_pct(idle_mode_e m, bit recv_side);
    case (m)
      IDLE_SEND: return recv_side ? 0 : 85;
      IDLE_RECV: return recv_side ? 85 : 0;
      IDLE_BOTH: return 37;
      default:   return 0;
    endcase
  endfunction

  // Drive result ready; a hold-off request blocks it for a long stretch
  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen    = 0;
    hold_left    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= !($urandom_range(99) < idle_pct(idle_mode, 1'b1));
      end
    end
  end

  // Check every result transaction
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      sb.match_result(res_t'{res_if.cell_is_mine, res_if.mine_count, res_if.frame_last});
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    int unsigned stuck;
    if (!rst_ni || (cell_if.valid && cell_if.ready) || (res_if.valid && res_if.ready) ||
        (reg_if.valid && reg_if.ready)) begin
      stuck = 0;
    end else begin
      stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STUCK_LIMIT);
        $display("grid_mine_neighbour_count_top verification failed");
        $finish;
      end
    end
  end

  // Offer one cell after a random gap and wait for its transaction
  task automatic send_cell(input bit is_mine);
    int unsigned gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < idle_pct(idle_mode, 1'b0)) gap++;
    repeat (gap) begin
      @(negedge clk_i);
      cell_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    cell_if.valid   <= 1'b1;
    cell_if.is_mine <= is_mine;
    do @(posedge clk_i); while (!cell_if.ready);
    sb.take_cell(is_mine);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    reg_if.valid <= 1'b1;
    reg_if.addr  <= idx;
    reg_if.data  <= val;
    do @(posedge clk_i); while (!reg_if.ready);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    reg_if.valid <= 1'b0;
  endtask

  // Drop input valid, wait for every awaited result, then let the pipeline settle
  task automatic wait_drained();
    @(negedge clk_i);
    cell_if.valid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    int unsigned    done_items;
    int unsigned    phase;
    int unsigned    cells;
    int unsigned    count;
    int unsigned    density;
    logic [CFG_DATA_W-1:0] rows_raw;
    logic [CFG_DATA_W-1:0] cols_raw;
    rst_ni          = 1'b0;
    cell_if.valid   = 1'b0;
    cell_if.is_mine = 1'b0;
    reg_if.valid    = 1'b0;
    reg_if.addr     = '0;
    reg_if.data     = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Both registers below range: one row of two cells
    write_reg(REG_ROW_COUNT, CFG_DATA_W'(0));
    write_reg(REG_COL_COUNT, CFG_DATA_W'(1));
    send_cell(1'b1);
    send_cell(1'b0);
    wait_drained();

    // Unused index, then a 3x3 ring of mines around a clear center
    write_reg(REG_SPARE_HI, CFG_DATA_W'(63));
    write_reg(REG_ROW_COUNT, CFG_DATA_W'(3));
    write_reg(REG_COL_COUNT, CFG_DATA_W'(3));
    for (int i = 0; i < 9; i++) send_cell(i != 4);
    wait_drained();

    // Restart mid-frame, then a clear frame over stale row contents
    write_reg(REG_ROW_COUNT, CFG_DATA_W'(2));
    write_reg(REG_COL_COUNT, CFG_DATA_W'(2));
    send_cell(1'b0);
    send_cell(1'b1);
    send_cell(1'b1);
    wait_drained();
    write_reg(REG_COL_COUNT, CFG_DATA_W'(2));
    repeat (4) send_cell(1'b0);
    wait_drained();

    // Rows above range, columns below: a broken frame left behind
    write_reg(REG_ROW_COUNT, CFG_DATA_W'(63));
    write_reg(REG_COL_COUNT, CFG_DATA_W'(0));
    send_cell(1'b1);
    send_cell(1'b0);
    send_cell(1'b0);
    send_cell(1'b1);
    wait_drained();

    // Back-pressure: hold the output while cells keep coming, then pause mid-frame
    write_reg(REG_ROW_COUNT, CFG_DATA_W'(4));
    write_reg(REG_COL_COUNT, CFG_DATA_W'(8));
    hold_req++;
    repeat (20) send_cell($urandom_range(1));
    wait_drained();
    repeat (12) send_cell($urandom_range(1));
    wait_drained();

    // Random frames: extremes first, then small grids, idle modes in rotation
    done_items = 0;
    phase      = 0;
    while (done_items < RANDOM_ITEMS || phase < 4) begin
      case (phase)
        0: begin
          rows_raw = CFG_DATA_W'(1);
          cols_raw = CFG_DATA_W'(32);
        end
        1: begin
          rows_raw = CFG_DATA_W'(2);
          cols_raw = CFG_DATA_W'(63);
        end
        2: begin
          rows_raw = CFG_DATA_W'(40);
          cols_raw = CFG_DATA_W'(2);
        end
        3: begin
          rows_raw = CFG_DATA_W'(0);
          cols_raw = CFG_DATA_W'(0);
        end
        default: begin
          rows_raw = CFG_DATA_W'($urandom_range(0, 6));
          cols_raw = CFG_DATA_W'($urandom_range(0, 8));
        end
      endcase
      idle_mode = idle_mode_e'(phase % 4);
      if ($urandom_range(3) == 0)
        write_reg(CFG_ADDR_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                  CFG_DATA_W'($urandom));
      write_reg(REG_ROW_COUNT, rows_raw);
      write_reg(REG_COL_COUNT, cols_raw);
      cells   = sb.frame_cells();
      count   = (cells >= 32) ? cells : cells * $urandom_range(1, 3);
      if ($urandom_range(2) == 0) count += $urandom_range(1, cells - 1);
      density = 25 * $urandom_range(0, 4);
      repeat (count) send_cell($urandom_range(99) < density);
      wait_drained();
      done_items += count;
      phase++;
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.waiting() != 0) $display("%0d results never arrived", sb.waiting());
    if (sb.faults == 0 && sb.waiting() == 0) begin
      $display("grid_mine_neighbour_count_top verification clean");
    end else begin
      $display("grid_mine_neighbour_count_top verification failed");
    end
    $finish;
  end

endmodule
